// ===== hw/rtl/xdr_pkg.sv =====
// Package with payload types and codes shared by the attribute decoder modules.
`timescale 1ns / 1ps
package xdr_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_record;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  attr_id;
        logic [63:0] attr_value;
        logic        last_result;
    } t_out_beat;

    // Work handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_PLAIN  = 2'd0,  // emit the value as it is
        OP_MODE   = 2'd1,  // OR in the type bits
        OP_BLOCKS = 2'd2   // round space used into blocks
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  attr_id;
        logic [63:0] value;
        logic [31:0] obj_type;
        logic        last;
    } t_work;

    localparam logic [3:0]  ID_UID    = 4'd4;
    localparam logic [3:0]  ID_GID    = 4'd5;
    localparam logic [3:0]  ID_TRUNC  = 4'd13;
    localparam logic [31:0] NOBODY_ID = 32'd65534;
    localparam logic [4:0]  BLOCK_SHIFT_RESET = 5'd12;
    localparam int unsigned QUEUE_DEPTH = 2;

    function automatic logic [15:0] type_bits(input logic [31:0] t);
        logic [15:0] r;
        case (t)
            32'd1:   r = 16'o100000;
            32'd2:   r = 16'o040000;
            32'd3:   r = 16'o060000;
            32'd4:   r = 16'o020000;
            32'd5:   r = 16'o120000;
            32'd6:   r = 16'o140000;
            32'd7:   r = 16'o010000;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/xdr_front.sv =====
// Front part: parses record bytes and emits work items for completed attributes.
`timescale 1ns / 1ps
module xdr_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  xdr_pkg::t_in_beat i_beat,
    output logic             o_valid,
    input  logic             i_ready,
    output xdr_pkg::t_work   o_work
);

    typedef enum logic [4:0] {
        PH_TYPE, PH_SIZE, PH_FILEID, PH_MODE, PH_NLINK, PH_OLEN, PH_OSTR, PH_OPAD,
        PH_GLEN, PH_GSTR, PH_GPAD, PH_SPACE, PH_ASEC, PH_ANS, PH_CSEC, PH_CNS,
        PH_MSEC, PH_MNS, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_otype, n_otype;
    logic [31:0] r_len, n_len;
    logic [31:0] r_id, n_id;
    logic        r_bad, n_bad;

    logic        fire, have;
    logic [3:0]  len;
    logic [63:0] acc_sh;
    logic [31:0] cnt_inc;
    logic [1:0]  pad;
    logic [7:0]  b;

    assign o_ready = i_ready;
    assign fire    = i_valid && i_ready;
    assign b       = i_beat.data_byte;
    assign acc_sh  = {r_acc[55:0], b};
    assign cnt_inc = r_cnt + 32'd1;
    assign pad     = 2'd0 - r_len[1:0];

    // Byte length of the fixed-width phases.
    always_comb begin
        case (r_phase)
            PH_SIZE, PH_FILEID, PH_SPACE, PH_ASEC, PH_CSEC, PH_MSEC: len = 4'd8;
            PH_OSTR, PH_OPAD, PH_GSTR, PH_GPAD, PH_DONE:               len = 4'd0;
            default:                                                   len = 4'd4;
        endcase
    end

    // Parse one byte.
    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_acc = r_acc; n_otype = r_otype;
        n_len = r_len; n_id = r_id; n_bad = r_bad;
        have = 1'b0;
        o_work = '{op: xdr_pkg::OP_PLAIN, attr_id: 4'd0, value: 64'd0,
                   obj_type: r_otype, last: 1'b0};
        if (len != 4'd0) begin
            n_acc = acc_sh;
            n_cnt = cnt_inc;
            if (cnt_inc >= {28'd0, len}) begin
                n_cnt   = '0;
                n_acc   = '0;
                n_phase = t_phase'(r_phase + 5'd1);
                o_work.value = acc_sh;
                case (r_phase)
                    PH_TYPE: n_otype = acc_sh[31:0];
                    PH_OLEN, PH_GLEN: begin
                        n_len = acc_sh[31:0];
                        n_id  = '0;
                        n_bad = 1'b0;
                        if (acc_sh[31:0] == 32'd0) begin
                            have = 1'b1;
                            o_work.attr_id = (r_phase == PH_OLEN) ? xdr_pkg::ID_UID
                                                                  : xdr_pkg::ID_GID;
                            o_work.value = '0;
                            n_phase = (r_phase == PH_OLEN) ? PH_GLEN : PH_SPACE;
                        end
                    end
                    PH_MODE: begin
                        have = 1'b1; o_work.attr_id = 4'd2;
                        o_work.op = xdr_pkg::OP_MODE;
                        o_work.value = {32'd0, acc_sh[31:0]};
                    end
                    PH_SPACE: begin
                        have = 1'b1; o_work.attr_id = 4'd6;
                        o_work.op = xdr_pkg::OP_BLOCKS;
                    end
                    PH_SIZE:   begin have = 1'b1; o_work.attr_id = 4'd0;  end
                    PH_FILEID: begin have = 1'b1; o_work.attr_id = 4'd1;  end
                    PH_NLINK:  begin have = 1'b1; o_work.attr_id = 4'd3;  end
                    PH_ASEC:   begin have = 1'b1; o_work.attr_id = 4'd7;  end
                    PH_ANS:    begin have = 1'b1; o_work.attr_id = 4'd8;  end
                    PH_CSEC:   begin have = 1'b1; o_work.attr_id = 4'd9;  end
                    PH_CNS:    begin have = 1'b1; o_work.attr_id = 4'd10; end
                    PH_MSEC:   begin have = 1'b1; o_work.attr_id = 4'd11; end
                    PH_MNS: begin
                        have = 1'b1; o_work.attr_id = 4'd12; o_work.last = 1'b1;
                        n_phase = PH_DONE;
                    end
                    default: ;
                endcase
            end
        end else if (r_phase == PH_OSTR || r_phase == PH_GSTR) begin
            if (b inside {[8'h30:8'h39]}) begin
                n_id = (r_id << 3) + (r_id << 1) + {28'd0, b[3:0]};
            end else begin
                n_bad = 1'b1;
            end
            n_cnt = cnt_inc;
            if (cnt_inc >= r_len) begin
                have = 1'b1;
                o_work.attr_id = (r_phase == PH_OSTR) ? xdr_pkg::ID_UID : xdr_pkg::ID_GID;
                o_work.value = {32'd0, n_bad ? xdr_pkg::NOBODY_ID : n_id};
                n_cnt = '0;
                if (pad != 2'd0) begin
                    n_phase = t_phase'(r_phase + 5'd1);
                end else begin
                    n_phase = (r_phase == PH_OSTR) ? PH_GLEN : PH_SPACE;
                end
            end
        end else if (r_phase == PH_OPAD || r_phase == PH_GPAD) begin
            n_cnt = cnt_inc;
            if (cnt_inc >= {30'd0, pad}) begin
                n_cnt   = '0;
                n_phase = (r_phase == PH_OPAD) ? PH_GLEN : PH_SPACE;
            end
        end
        // Final beat: report truncation unless the record completed.
        if (i_beat.end_of_record) begin
            if (r_phase != PH_DONE && !(r_phase == PH_MNS && have)) begin
                have = 1'b1;
                o_work = '{op: xdr_pkg::OP_PLAIN, attr_id: xdr_pkg::ID_TRUNC,
                           value: 64'd0, obj_type: r_otype, last: 1'b1};
            end
            n_phase = PH_TYPE; n_cnt = '0; n_acc = '0; n_otype = '0;
            n_len = '0; n_id = '0; n_bad = 1'b0;
        end
        o_valid = fire && have;
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE; r_cnt <= '0; r_acc <= '0; r_otype <= '0;
            r_len <= '0; r_id <= '0; r_bad <= 1'b0;
        end else if (fire) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_acc <= n_acc; r_otype <= n_otype;
            r_len <= n_len; r_id <= n_id; r_bad <= n_bad;
        end
    end

endmodule

// ===== hw/rtl/xdr_queue.sv =====
// Short work queue between the front and back parts.
`timescale 1ns / 1ps
module xdr_queue #(
    parameter int unsigned DEPTH = xdr_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  xdr_pkg::t_work i_work,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output xdr_pkg::t_work o_work
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    xdr_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH)) || i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_work  = r_mem[r_rp];
    assign push    = i_valid;
    assign pop     = o_valid && i_ready;

    // Storage, written in the cycle of the push.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_work;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(DEPTH)) && i_valid |-> i_ready) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count out of range");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 1'b1) else $error("queue count slip");
`endif

endmodule

// ===== hw/rtl/xdr_back.sv =====
// Back part: finishes mode and block count values and holds the output register.
`timescale 1ns / 1ps
module xdr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [4:0]        i_block_shift,
    input  logic              i_valid,
    output logic              o_ready,
    input  xdr_pkg::t_work    i_work,
    output logic              o_valid,
    input  logic              i_ready,
    output xdr_pkg::t_out_beat o_beat
);

    logic              r_valid;
    xdr_pkg::t_out_beat r_beat;
    logic [63:0]       val, mask, q;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    // Final value of the attribute.
    always_comb begin
        mask = (64'd1 << i_block_shift) - 64'd1;
        q    = i_work.value >> i_block_shift;
        case (i_work.op)
            xdr_pkg::OP_MODE:   val = i_work.value | {48'd0, xdr_pkg::type_bits(i_work.obj_type)};
            xdr_pkg::OP_BLOCKS: val = q + {63'd0, (i_work.value & mask) != 64'd0};
            default:            val = i_work.value;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_beat <= '{attr_id: i_work.attr_id, attr_value: val,
                        last_result: i_work.last};
        end
    end

endmodule

// ===== hw/rtl/xdr_file_attr_decoder_core.sv =====
// Top level of the streaming file-attribute record decoder.
// A result is written to the work queue, then to the output register, before it is valid.
// Only output stalls delay a result further once its last byte is taken.
// Throughput: one byte per cycle while the queue accepts work; the parser updates each beat.
// A two-entry queue and the output register let input run while output stalls.
// Reset is synchronous, active low; block_shift returns to 12, parser to the type field.
`timescale 1ns / 1ps
module xdr_file_attr_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = xdr_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  xdr_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output xdr_pkg::t_out_beat o_data
);

    logic [4:0]     r_block_shift;
    logic           f_valid, q_ready, q_valid, b_ready;
    xdr_pkg::t_work f_work, q_work;

    assign o_cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_shift <= xdr_pkg::BLOCK_SHIFT_RESET;
        end else if (i_cfg_valid) begin
            r_block_shift <= i_cfg_data;
        end
    end

    xdr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_beat(i_data),
        .o_valid(f_valid), .i_ready(q_ready), .o_work(f_work)
    );

    xdr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .i_work(f_work), .o_ready(q_ready),
        .o_valid(q_valid), .i_ready(b_ready), .o_work(q_work)
    );

    xdr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_block_shift(r_block_shift),
        .i_valid(q_valid), .o_ready(b_ready), .i_work(q_work),
        .o_valid(o_valid), .i_ready(i_ready), .o_beat(o_data)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the streaming file-attribute record decoder.
`timescale 1ns / 1ps
module tb;

    // Record fields in the order the parser walks through them.
    typedef enum int {
        PH_TYPE, PH_SIZE, PH_FILEID, PH_MODE, PH_NLINK, PH_OLEN, PH_OSTR, PH_OPAD,
        PH_GLEN, PH_GSTR, PH_GPAD, PH_SPACE, PH_ASEC, PH_ANS, PH_CSEC, PH_CNS,
        PH_MSEC, PH_MNS, PH_DONE
    } t_field;

    localparam logic [3:0] ATTR_SIZE   = 4'd0;
    localparam logic [3:0] ATTR_FILEID = 4'd1;
    localparam logic [3:0] ATTR_MODE   = 4'd2;
    localparam logic [3:0] ATTR_NLINK  = 4'd3;
    localparam logic [3:0] ATTR_BLOCKS = 4'd6;
    localparam logic [3:0] ATTR_ASEC   = 4'd7;
    localparam logic [3:0] ATTR_ANS    = 4'd8;
    localparam logic [3:0] ATTR_CSEC   = 4'd9;
    localparam logic [3:0] ATTR_CNS    = 4'd10;
    localparam logic [3:0] ATTR_MSEC   = 4'd11;
    localparam logic [3:0] ATTR_MNS    = 4'd12;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         LONG_HOLD   = 300;
    localparam int         ITEM_TARGET = 1400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [4:0]         i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    xdr_pkg::t_in_beat  i_data = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    xdr_pkg::t_out_beat o_data;

    xdr_file_attr_decoder_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #1 i_clk = ~i_clk;

    // Bytes waiting to be sent and attributes waiting to come out.
    xdr_pkg::t_in_beat  byte_feed[$];
    xdr_pkg::t_out_beat attr_expected[$];
    logic [7:0] rec_bytes[$];
    int         items_queued = 0;
    int         mismatches = 0;
    int         idle_cycles = 0;
    logic       accepted_any;
    logic       long_hold_req = 1'b0;

    // Decoder shadow state.
    logic [4:0]  blk_shift;
    t_field      fld;
    logic [31:0] fld_count;
    logic [63:0] acc;
    logic [31:0] obj_kind;
    logic [31:0] name_len;
    logic [31:0] id_acc;
    logic        id_bad;
    logic        rec_done;

    function automatic int fixed_len(input t_field f);
        case (f)
            PH_SIZE, PH_FILEID, PH_SPACE, PH_ASEC, PH_CSEC, PH_MSEC: return 8;
            PH_TYPE, PH_MODE, PH_NLINK, PH_OLEN, PH_GLEN, PH_ANS, PH_CNS, PH_MNS:
                return 4;
            default: return 0;
        endcase
    endfunction

    function automatic logic [31:0] pad_bytes(input logic [31:0] n);
        return (32'd4 - (n & 32'h3)) & 32'h3;
    endfunction

    function automatic logic [31:0] posix_kind(input logic [31:0] t);
        case (t)
            32'd1:   return 32'o100000;
            32'd2:   return 32'o040000;
            32'd3:   return 32'o060000;
            32'd4:   return 32'o020000;
            32'd5:   return 32'o120000;
            32'd6:   return 32'o140000;
            32'd7:   return 32'o010000;
            default: return 32'd0;
        endcase
    endfunction

    task clear_record();
        fld = PH_TYPE;
        fld_count = '0;
        acc = '0;
        obj_kind = '0;
        name_len = '0;
        id_acc = '0;
        id_bad = 1'b0;
        rec_done = 1'b0;
    endtask

    // Close an id string and move to its padding or straight past it.
    task finish_name(input t_field pad_fld);
        fld_count = '0;
        if (pad_bytes(name_len) != 0) begin
            fld = pad_fld;
        end else begin
            fld = (pad_fld == PH_OPAD) ? PH_GLEN : PH_SPACE;
        end
    endtask

    // Advance the shadow decoder by one byte and queue any attribute it yields.
    task decode_byte(input xdr_pkg::t_in_beat b);
        logic               have;
        xdr_pkg::t_out_beat r;
        logic [63:0]        a;
        logic [63:0]        mask;
        t_field             f;
        have = 1'b0;
        r = '0;
        f = fld;
        if (!rec_done && f != PH_DONE) begin
            if (fixed_len(f) != 0) begin
                acc = {acc[55:0], b.data_byte};
                fld_count = fld_count + 1;
                if (fld_count >= fixed_len(f)) begin
                    a = acc;
                    fld_count = '0;
                    acc = '0;
                    fld = t_field'(f + 1);
                    case (f)
                        PH_TYPE: obj_kind = a[31:0];
                        PH_OLEN, PH_GLEN: begin
                            name_len = a[31:0];
                            id_acc = '0;
                            id_bad = 1'b0;
                            if (name_len == 0) begin
                                have = 1'b1;
                                r.attr_id = (f == PH_OLEN) ? xdr_pkg::ID_UID
                                                           : xdr_pkg::ID_GID;
                                finish_name(f == PH_OLEN ? PH_OPAD : PH_GPAD);
                            end
                        end
                        PH_MODE: begin
                            have = 1'b1;
                            r.attr_id = ATTR_MODE;
                            r.attr_value = {32'd0, a[31:0] | posix_kind(obj_kind)};
                        end
                        PH_SPACE: begin
                            mask = (64'd1 << blk_shift) - 64'd1;
                            have = 1'b1;
                            r.attr_id = ATTR_BLOCKS;
                            r.attr_value = (a >> blk_shift) +
                                           ((a & mask) != 0 ? 64'd1 : 64'd0);
                        end
                        PH_MNS: begin
                            have = 1'b1;
                            r.attr_id = ATTR_MNS;
                            r.attr_value = a;
                            r.last_result = 1'b1;
                            rec_done = 1'b1;
                            fld = PH_DONE;
                        end
                        default: begin
                            have = 1'b1;
                            r.attr_value = a;
                            case (f)
                                PH_SIZE:   r.attr_id = ATTR_SIZE;
                                PH_FILEID: r.attr_id = ATTR_FILEID;
                                PH_NLINK:  r.attr_id = ATTR_NLINK;
                                PH_ASEC:   r.attr_id = ATTR_ASEC;
                                PH_ANS:    r.attr_id = ATTR_ANS;
                                PH_CSEC:   r.attr_id = ATTR_CSEC;
                                PH_CNS:    r.attr_id = ATTR_CNS;
                                default:   r.attr_id = ATTR_MSEC;
                            endcase
                        end
                    endcase
                end
            end else if (f == PH_OSTR || f == PH_GSTR) begin
                if (b.data_byte >= CHAR_ZERO && b.data_byte <= CHAR_NINE) begin
                    id_acc = id_acc * 10 + {24'd0, b.data_byte - CHAR_ZERO};
                end else begin
                    id_bad = 1'b1;
                end
                fld_count = fld_count + 1;
                if (fld_count >= name_len) begin
                    have = 1'b1;
                    r.attr_id = (f == PH_OSTR) ? xdr_pkg::ID_UID : xdr_pkg::ID_GID;
                    r.attr_value = id_bad ? {32'd0, xdr_pkg::NOBODY_ID} : {32'd0, id_acc};
                    finish_name(t_field'(f + 1));
                end
            end else begin
                fld_count = fld_count + 1;
                if (fld_count >= pad_bytes(name_len)) begin
                    fld_count = '0;
                    fld = (f == PH_OPAD) ? PH_GLEN : PH_SPACE;
                end
            end
        end
        // The end mark always closes the record; an unfinished one is an error.
        if (b.end_of_record) begin
            if (!rec_done) begin
                have = 1'b1;
                r = '0;
                r.attr_id = xdr_pkg::ID_TRUNC;
                r.last_result = 1'b1;
            end
            clear_record();
        end
        if (have) attr_expected.push_back(r);
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sender: one byte per beat, with random gaps between beats.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) decode_byte(i_data);
            if (i_valid && !o_ready) begin
                // Hold the beat until it is taken.
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (byte_feed.size() != 0) begin
                i_data <= byte_feed.pop_front();
                i_valid <= 1'b1;
                send_gap <= gap_len();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result beat and stalls at random.
    int  hold_left = 0;
    logic long_hold_done = 1'b0;
    xdr_pkg::t_out_beat want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (attr_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: id %0d value %h last %0b",
                                 o_data.attr_id, o_data.attr_value, o_data.last_result);
                end else begin
                    want = attr_expected.pop_front();
                    if (o_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp id %0d value %h last %0b, ",
                                      "got id %0d value %h last %0b"},
                                     want.attr_id, want.attr_value, want.last_result,
                                     o_data.attr_id, o_data.attr_value, o_data.last_result);
                    end
                end
            end
            if (long_hold_req && !long_hold_done) begin
                long_hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                i_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else begin
                hold_left <= gap_len();
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge i_clk) begin
        accepted_any = (i_valid && o_ready) || (o_valid && i_ready) ||
                       (i_cfg_valid && o_cfg_ready);
        idle_cycles <= accepted_any ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[xdr_file_attr_decoder_core] ERROR");
            $finish;
        end
    end

    task put_field(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--) rec_bytes.push_back(v[8*i +: 8]);
    endtask

    function automatic logic [7:0] non_digit();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c >= CHAR_ZERO && c <= CHAR_NINE) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task put_id(input int len, input bit bad);
        int where;
        where = (len > 0) ? $urandom_range(0, len - 1) : 0;
        put_field(64'(len), 4);
        for (int i = 0; i < len; i++)
            rec_bytes.push_back(bad && i == where ? non_digit()
                                : CHAR_ZERO + 8'($urandom_range(0, 9)));
        for (int i = 0; i < pad_bytes(32'(len)); i++)
            rec_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic logic [63:0] rand_word(input int n);
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return '0;
        if (p == 1) return n == 8 ? '1 : 64'hFFFF_FFFF;
        return n == 8 ? {$urandom, $urandom} : {32'd0, $urandom};
    endfunction

    // Lay out one well-formed record in rec_bytes.
    task build_record(input logic [31:0] kind, input int olen, input bit obad,
                      input int glen, input bit gbad);
        rec_bytes.delete();
        put_field({32'd0, kind}, 4);
        put_field(rand_word(8), 8);
        put_field(rand_word(8), 8);
        put_field(rand_word(4), 4);
        put_field(rand_word(4), 4);
        put_id(olen, obad);
        put_id(glen, gbad);
        for (int i = 0; i < 7; i++) put_field(rand_word(i % 2 ? 4 : 8), i % 2 ? 4 : 8);
    endtask

    // Send rec_bytes, cut short after byte cut when cut >= 0, else with trailing bytes.
    task send_record(input int cut, input int trailing);
        xdr_pkg::t_in_beat b;
        int n;
        if (cut >= 0 && cut < rec_bytes.size() - 1) begin
            n = cut + 1;
        end else begin
            for (int i = 0; i < trailing; i++)
                rec_bytes.push_back(8'($urandom_range(0, 255)));
            n = rec_bytes.size();
        end
        for (int i = 0; i < n; i++) begin
            b.data_byte = rec_bytes[i];
            b.end_of_record = (i == n - 1);
            byte_feed.push_back(b);
        end
        items_queued += n;
    endtask

    task random_record();
        int p;
        int cut;
        int noise_len;
        p = $urandom_range(0, 99);
        build_record(32'($urandom_range(0, 9)), $urandom_range(0, 7),
                     $urandom_range(0, 3) == 0,
                     $urandom_range(0, 7), $urandom_range(0, 3) == 0);
        if (p < 10) begin
            // Noise: a short burst of random bytes.
            rec_bytes.delete();
            noise_len = $urandom_range(1, 12);
            for (int i = 0; i < noise_len; i++)
                rec_bytes.push_back(8'($urandom_range(0, 255)));
            cut = -1;
        end else if (p < 40) begin
            cut = $urandom_range(0, rec_bytes.size() - 2);
        end else begin
            cut = -1;
        end
        send_record(cut, $urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
    endtask

    task wait_drained();
        while (byte_feed.size() != 0 || i_valid || attr_expected.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task write_shift(input logic [4:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        blk_shift = v;
        i_cfg_valid <= 1'b0;
    endtask

    logic [4:0] shift_plan[5] = '{5'd0, 5'd20, 5'd31, 5'd1, 5'd12};

    initial begin
        blk_shift = xdr_pkg::BLOCK_SHIFT_RESET;
        clear_record();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset block size with extremes, then the special cases.
        build_record(32'd1, 0, 1'b0, 0, 1'b0);
        send_record(-1, 0);
        build_record(32'd7, 10, 1'b0, 3, 1'b1);
        send_record(-1, 3);
        build_record(32'd2, 2, 1'b0, 2, 1'b0);
        send_record(0, 0);
        rec_bytes.delete();
        put_field(64'd3, 4);
        for (int i = 0; i < 28; i++) rec_bytes.push_back(8'hFF);
        put_field(64'hFFFF_FFFF, 4);
        for (int i = 0; i < 5; i++) rec_bytes.push_back(CHAR_ZERO + 8'd9);
        send_record(-1, 0);
        wait_drained();

        // Random records under a sequence of block sizes.
        for (int k = 0; k < 5; k++) begin
            write_shift(k == 4 ? 5'($urandom_range(0, 31)) : shift_plan[k]);
            while (items_queued < (k + 1) * ITEM_TARGET / 5) begin
                random_record();
                if (k == 1 && !long_hold_req && items_queued > ITEM_TARGET / 4)
                    long_hold_req = 1'b1;
                while (byte_feed.size() > 200) @(posedge i_clk);
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("[xdr_file_attr_decoder_core] OK");
        end else begin
            $display("[xdr_file_attr_decoder_core] ERROR");
        end
        $finish;
    end

endmodule
